// ----- sv/csma_line_backoff_arbiter_unit_defines.svh -----
// Assertion macros shared by the backoff arbiter RTL.
`ifndef CSMA_LINE_BACKOFF_ARBITER_UNIT_DEFINES_SVH
`define CSMA_LINE_BACKOFF_ARBITER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CLB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CLB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define CLB_ASSERT(label, clk, rst_n, prop, msg)
`define CLB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- sv/clba_pkg.sv -----
// Shared types and constants for the backoff arbiter.
package clba_pkg;
  localparam int Stations = 4;
  localparam int QueueDepth = 16;
  localparam int StIdxW = 2;
  localparam logic [12:0] TimerMax = 13'd8191;
  localparam logic [1:0] OUT_IDLE = 2'd0;
  localparam logic [1:0] OUT_SENT = 2'd1;
  localparam logic [1:0] OUT_COLL = 2'd2;
  localparam logic CFG_FRAME_SLOTS = 1'b0;
  localparam logic CFG_ACTIVE = 1'b1;

  typedef struct packed {
    logic load;        // latch input, take arrivals, pick attempts
    logic resolve;     // apply success or collision-wide updates
    logic backoff;     // apply backoff of station st
    logic div_start;   // start remainder of station st
    logic out_load;    // copy the slot result into the output register
    logic [StIdxW-1:0] st;
  } clba_cmd_t;

  typedef struct packed {
    logic div_done;
    logic tried;       // station st attempted
    logic collision;   // more than one attempt
    logic last_st;     // st is the last active station
  } clba_sts_t;
endpackage

// ----- sv/clba_ctrl.sv -----
// Sequencer: load, resolve, walk stations for backoff after a collision, then output.
module clba_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output clba_pkg::clba_cmd_t cmd_o,
  input  clba_pkg::clba_sts_t sts_i
);
  import clba_pkg::*;
  `include "csma_line_backoff_arbiter_unit_defines.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RES  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [StIdxW-1:0] st_q, st_d;
  logic ov_q, ov_d;

  // Accept a word whenever idle; the output register holds the previous result
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    st_d = st_q;
    ov_d = ov_q;
    cmd_o = '0;
    cmd_o.st = st_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d = S_RES;
        end
      end
      S_RES: begin
        cmd_o.resolve = 1'b1;
        st_d = '0;
        state_d = sts_i.collision ? S_CHK : S_OUT;
      end
      S_CHK: begin
        if (sts_i.tried) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else if (sts_i.last_st) begin
          state_d = S_OUT;
        end else begin
          st_d = st_q + 1'b1;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.backoff = 1'b1;
          if (sts_i.last_st) state_d = S_OUT;
          else begin
            st_d = st_q + 1'b1;
            state_d = S_CHK;
          end
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  `CLB_ASSERT(a_idle_accept, clk_i, rst_ni, !(in_ready_o && state_q != S_IDLE),
    "accept outside idle")
  `CLB_ASSERT_NEXT(a_load_res, clk_i, rst_ni, cmd_o.load, state_q == S_RES,
    "load not followed by resolve")
  `CLB_ASSERT(a_one_cmd, clk_i, rst_ni,
    $onehot0({cmd_o.load, cmd_o.resolve, cmd_o.backoff, cmd_o.div_start, cmd_o.out_load}),
    "several commands at once")
endmodule

// ----- sv/clba_rem.sv -----
// Restoring remainder unit: 16-bit dividend by 14-bit divisor, one bit a cycle.
module clba_rem (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [15:0] num_i,
  input  logic [13:0] den_i,
  output logic done_o,
  output logic [13:0] rem_o
);
  logic [15:0] num_q, num_d;
  logic [13:0] den_q, den_d;
  logic [14:0] rem_q, rem_d;
  logic [4:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [15:0] trial;

  assign trial = {rem_q, num_q[15]} - {2'b00, den_q};
  assign done_o = busy_q && (cnt_q == 5'd0);
  assign rem_o = rem_q[13:0];

  // Shift in one dividend bit and subtract when it fits
  always_comb begin
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == 5'd0) busy_d = 1'b0;
      else begin
        rem_d = trial[15] ? {rem_q[13:0], num_q[15]} : trial[14:0];
        num_d = {num_q[14:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end
endmodule

// ----- sv/clba_dpath.sv -----
// Station state, line state, counters and result register.
module clba_dpath (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic [3:0] arrivals_i,
  input  logic [63:0] backoff_random_i,
  input  clba_pkg::clba_cmd_t cmd_i,
  output clba_pkg::clba_sts_t sts_o,
  output logic [1:0] slot_outcome_o,
  output logic [1:0] sender_o,
  output logic line_held_o,
  output logic [3:0] excess_collision_mask_o,
  output logic [3:0] drop_mask_o,
  output logic [31:0] total_sent_slots_o,
  output logic [31:0] total_collisions_o
);
  import clba_pkg::*;

  logic [7:0] fslots_q;
  logic [2:0] active_q;
  logic [4:0] pend_q [Stations];
  logic [7:0] head_q [Stations];
  logic [12:0] wait_q [Stations];
  logic [4:0] ccnt_q [Stations];
  logic [12:0] base_q [Stations];
  logic busy_q;
  logic [StIdxW-1:0] talker_q;
  logic [31:0] sent_q, coll_q;
  logic [Stations-1:0] tried_q;
  logic [63:0] rnd_q;
  logic [3:0] drops_q, excess_q;
  logic [1:0] outc_q, sender_q;
  logic [7:0] flen;
  logic [2:0] nact;
  logic [2:0] ntries;
  logic [StIdxW-1:0] who;
  logic [15:0] r_st;
  logic [13:0] rem;
  logic div_done;
  logic [4:0] pend_a [Stations];
  logic [7:0] head_a [Stations];
  logic [Stations-1:0] try_a;

  assign flen = (fslots_q == 8'd0) ? 8'd1 : fslots_q;
  assign nact = (active_q > 3'(Stations)) ? 3'(Stations) : active_q;
  assign r_st = rnd_q[16*cmd_i.st +: 16];

  // Remainder for backoff: r mod 3 on first collision, else r mod (base+1)
  clba_rem u_rem (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .num_i(r_st),
    .den_i((ccnt_q[cmd_i.st] == 5'd0) ? 14'd3 : {1'b0, base_q[cmd_i.st]} + 14'd1),
    .done_o(div_done),
    .rem_o(rem)
  );

  // Arrival and attempt decision per station
  always_comb begin
    ntries = '0;
    who = '0;
    for (int s = 0; s < Stations; s++) begin
      pend_a[s] = pend_q[s];
      head_a[s] = head_q[s];
      try_a[s] = 1'b0;
      if (3'(s) < nact) begin
        if (arrivals_i[s] && pend_q[s] < 5'(QueueDepth)) begin
          if (pend_q[s] == 5'd0) head_a[s] = flen;
          pend_a[s] = pend_q[s] + 5'd1;
        end
        if (wait_q[s] == 13'd0 && pend_a[s] != 5'd0 &&
            (!busy_q || talker_q == StIdxW'(s))) begin
          try_a[s] = 1'b1;
          ntries = ntries + 3'd1;
          who = StIdxW'(s);
        end
      end
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.tried = tried_q[cmd_i.st];
  assign sts_o.collision = (outc_q == OUT_COLL);
  assign sts_o.last_st = ({1'b0, cmd_i.st} + 3'd1) >= nact;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fslots_q <= 8'd1;
      active_q <= 3'd4;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_FRAME_SLOTS) fslots_q <= cfg_data_i;
      else active_q <= cfg_data_i[2:0];
    end
  end

  // Station and line updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stations; s++) begin
        pend_q[s] <= '0; head_q[s] <= '0; wait_q[s] <= '0;
        ccnt_q[s] <= '0; base_q[s] <= '0;
      end
      busy_q <= 1'b0; talker_q <= '0; sent_q <= '0; coll_q <= '0;
      tried_q <= '0; drops_q <= '0; excess_q <= '0; rnd_q <= '0;
      outc_q <= OUT_IDLE; sender_q <= '0;
    end else if (cmd_i.load) begin
      rnd_q <= backoff_random_i;
      tried_q <= try_a;
      excess_q <= '0;
      sender_q <= who;
      outc_q <= (ntries == 3'd0) ? OUT_IDLE : (ntries == 3'd1) ? OUT_SENT : OUT_COLL;
      for (int s = 0; s < Stations; s++) begin
        drops_q[s] <= (3'(s) < nact) && arrivals_i[s] && pend_q[s] >= 5'(QueueDepth);
        pend_q[s] <= pend_a[s];
        head_q[s] <= head_a[s];
        if (3'(s) < nact && wait_q[s] != 13'd0) wait_q[s] <= wait_q[s] - 13'd1;
      end
    end else if (cmd_i.resolve) begin
      if (outc_q == OUT_SENT) begin
        logic [7:0] h;
        logic [4:0] p;
        h = (head_q[sender_q] > 8'd0) ? head_q[sender_q] - 8'd1 : 8'd0;
        p = pend_q[sender_q];
        if (h == 8'd0) begin
          p = p - 5'd1;
          h = (p > 5'd0) ? flen : 8'd0;
        end
        head_q[sender_q] <= h;
        pend_q[sender_q] <= p;
        ccnt_q[sender_q] <= '0;
        sent_q <= sent_q + 32'd1;
        busy_q <= (p > 5'd0);
        talker_q <= (p > 5'd0) ? sender_q : '0;
      end else begin
        sender_q <= '0;
        if (outc_q == OUT_COLL) begin
          coll_q <= coll_q + 32'd1;
          busy_q <= 1'b0;
          talker_q <= '0;
        end
      end
    end else if (cmd_i.backoff) begin
      logic [4:0] c;
      logic [13:0] b2;
      logic [13:0] w;
      logic [7:0] h;
      logic [4:0] p;
      c = ccnt_q[cmd_i.st];
      b2 = {base_q[cmd_i.st], 1'b0};
      if (b2 > {1'b0, TimerMax}) b2 = {1'b0, TimerMax};
      w = b2 + rem;
      if (w > {1'b0, TimerMax}) w = {1'b0, TimerMax};
      if (c == 5'd0) begin
        base_q[cmd_i.st] <= 13'd2 + rem[12:0];
        wait_q[cmd_i.st] <= 13'd2 + rem[12:0];
      end else if (c <= 5'd10) begin
        base_q[cmd_i.st] <= b2[12:0];
        wait_q[cmd_i.st] <= w[12:0];
      end
      if (c > 5'd16) begin
        excess_q[cmd_i.st] <= 1'b1;
        c = 5'd0;
        h = head_q[cmd_i.st];
        p = pend_q[cmd_i.st];
        if (p > 5'd0) begin
          if (h > 8'd0) h = h - 8'd1;
          if (h == 8'd0) begin
            p = p - 5'd1;
            h = (p > 5'd0) ? flen : 8'd0;
          end
        end
        head_q[cmd_i.st] <= h;
        pend_q[cmd_i.st] <= p;
      end
      ccnt_q[cmd_i.st] <= c + 5'd1;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      slot_outcome_o <= outc_q;
      sender_o <= (outc_q == OUT_SENT) ? sender_q : '0;
      line_held_o <= busy_q;
      excess_collision_mask_o <= excess_q;
      drop_mask_o <= drops_q;
      total_sent_slots_o <= sent_q;
      total_collisions_o <= coll_q;
    end
  end
endmodule

// ----- sv/csma_line_backoff_arbiter_unit.sv -----
// Top level of the shared-line CSMA/CD backoff arbiter.
// One input word per time slot: arrival mask and four 16-bit random draws.
// One result word per input: outcome, sender, line hold, excess and drop
// masks, and the wrapping sent-slot and collision totals.
// Both channels are valid/ready; configuration is a plain write port
// (index 0 frame_slots, index 1 active_stations), written while idle.
// An idle or send slot passes through load, resolve and output load before
// its result is valid. A collision slot walks the active stations one at a
// time: each station is checked, and each station that collided also runs
// the bit-serial remainder unit before its backoff is applied. Items are
// handled one at a time; the next word is taken the cycle after the result
// is loaded, and the remainder unit sets the worst case.
// A finished result sits in the output register; the next word can be
// accepted while it waits, but the following result holds until taken.
// Reset clears all station state, the line, counters, and sets
// frame_slots to 1 and active_stations to 4.
module csma_line_backoff_arbiter_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [3:0] arrivals_i,
  input  logic [63:0] backoff_random_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [1:0] slot_outcome_o,
  output logic [1:0] sender_o,
  output logic line_held_o,
  output logic [3:0] excess_collision_mask_o,
  output logic [3:0] drop_mask_o,
  output logic [31:0] total_sent_slots_o,
  output logic [31:0] total_collisions_o
);
  import clba_pkg::*;

  clba_cmd_t cmd;
  clba_sts_t sts;

  clba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  clba_dpath u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .arrivals_i, .backoff_random_i,
    .cmd_i(cmd), .sts_o(sts),
    .slot_outcome_o, .sender_o, .line_held_o,
    .excess_collision_mask_o, .drop_mask_o,
    .total_sent_slots_o, .total_collisions_o
  );
endmodule
